FILE: rtl/mmep_pkg.sv
package mmep_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned TDATA_W = 24;

  localparam logic [BYTE_W-1:0] META_START     = 8'hFF;
  localparam logic [BYTE_W-1:0] META_COPYRIGHT = 8'h02;
  localparam logic [BYTE_W-1:0] META_TITLE     = 8'h03;
  localparam logic [BYTE_W-1:0] META_TEMPO     = 8'h51;
  localparam logic [BYTE_W-1:0] TEMPO_LEN      = 8'd3;

  localparam logic [KIND_W-1:0] KIND_COPYRIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TITLE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEMPO     = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_LENGTH  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               text_end;
  } res_t;

endpackage

FILE: rtl/mmep_core.sv
module mmep_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_accept,
  input  logic [mmep_pkg::BYTE_W-1:0] data_byte,
  input  logic                        last_byte,
  output mmep_pkg::res_t              res
);

  mmep_pkg::phase_t              phase_r, phase_nxt;
  logic [mmep_pkg::BYTE_W-1:0]   meta_kind_r, meta_kind_nxt;
  logic [mmep_pkg::BYTE_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [mmep_pkg::VALUE_W-1:0]  tempo_accum_r, tempo_accum_nxt;
  logic                          tempo_wanted_r, tempo_wanted_nxt;
  logic                          final_byte;
  logic                          is_text;

  assign final_byte = (bytes_left_r <= 8'd1);
  assign is_text    = (meta_kind_r == mmep_pkg::META_COPYRIGHT) ||
                      (meta_kind_r == mmep_pkg::META_TITLE);

  always_comb begin
    phase_nxt        = phase_r;
    meta_kind_nxt    = meta_kind_r;
    bytes_left_nxt   = bytes_left_r;
    tempo_accum_nxt  = tempo_accum_r;
    tempo_wanted_nxt = tempo_wanted_r;
    res              = '0;
    case (phase_r)
      mmep_pkg::PH_IDLE: begin
        if (data_byte == mmep_pkg::META_START) begin
          phase_nxt = mmep_pkg::PH_TYPE;
        end
      end
      mmep_pkg::PH_TYPE: begin
        meta_kind_nxt = data_byte;
        phase_nxt     = mmep_pkg::PH_LENGTH;
      end
      mmep_pkg::PH_LENGTH: begin
        bytes_left_nxt   = data_byte;
        tempo_accum_nxt  = '0;
        tempo_wanted_nxt = (meta_kind_r == mmep_pkg::META_TEMPO) &&
                           (data_byte == mmep_pkg::TEMPO_LEN);
        phase_nxt        = (data_byte == 8'd0) ? mmep_pkg::PH_IDLE : mmep_pkg::PH_PAYLOAD;
      end
      mmep_pkg::PH_PAYLOAD: begin
        bytes_left_nxt = 8'(bytes_left_r - 8'd1);
        if (is_text) begin
          res.valid    = 1'b1;
          res.kind     = (meta_kind_r == mmep_pkg::META_COPYRIGHT) ?
                         mmep_pkg::KIND_COPYRIGHT : mmep_pkg::KIND_TITLE;
          res.value    = {16'd0, data_byte};
          res.text_end = final_byte;
        end else if (tempo_wanted_r) begin
          tempo_accum_nxt = {tempo_accum_r[15:0], data_byte};
          if (final_byte) begin
            res.valid = 1'b1;
            res.kind  = mmep_pkg::KIND_TEMPO;
            res.value = {tempo_accum_r[15:0], data_byte};
          end
        end
        if (final_byte) begin
          phase_nxt        = mmep_pkg::PH_IDLE;
          bytes_left_nxt   = '0;
          tempo_wanted_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = mmep_pkg::PH_IDLE;
      end
    endcase
    if (last_byte) begin
      phase_nxt        = mmep_pkg::PH_IDLE;
      meta_kind_nxt    = '0;
      bytes_left_nxt   = '0;
      tempo_accum_nxt  = '0;
      tempo_wanted_nxt = 1'b0;
    end
    if (!byte_accept) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= mmep_pkg::PH_IDLE;
      meta_kind_r    <= '0;
      bytes_left_r   <= '0;
      tempo_accum_r  <= '0;
      tempo_wanted_r <= 1'b0;
    end else if (byte_accept) begin
      phase_r        <= phase_nxt;
      meta_kind_r    <= meta_kind_nxt;
      bytes_left_r   <= bytes_left_nxt;
      tempo_accum_r  <= tempo_accum_nxt;
      tempo_wanted_r <= tempo_wanted_nxt;
    end
  end

  a_res_from_payload: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (phase_r == mmep_pkg::PH_PAYLOAD))
    else $error("Result produced outside a payload.");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_accept && last_byte) |=> (phase_r == mmep_pkg::PH_IDLE) && !tempo_wanted_r)
    else $error("Last byte did not return the parser to idle.");

  a_tempo_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.kind == mmep_pkg::KIND_TEMPO) |-> (!res.text_end && final_byte))
    else $error("Tempo result with text end or before its final byte.");

endmodule

FILE: rtl/mmep_out.sv
module mmep_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mmep_pkg::res_t               res,
  output logic                         space_ok,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mmep_pkg::KIND_W-1:0]  kind,
  output logic [mmep_pkg::VALUE_W-1:0] value,
  output logic                         text_end
);

  logic           main_valid_r, main_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  mmep_pkg::res_t main_r, main_nxt;
  mmep_pkg::res_t skid_r, skid_nxt;
  logic           main_free;

  assign main_free = !main_valid_r || out_tready;
  assign space_ok  = !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (main_free) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = res.valid;
        main_nxt       = res;
      end
    end else if (res.valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = main_valid_r;
  assign kind       = main_r.kind;
  assign value      = main_r.value;
  assign text_end   = main_r.text_end;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("Skid entry held while the output register is empty.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res.valid)
    else $error("Result pushed while the skid entry is occupied.");

endmodule

FILE: rtl/midi_meta_event_parser_top.sv
// A result is registered into the output register that drives the out_ channel, or
// into the skid entry while that register is stalled, on the transfer of its byte.
// Throughput: one byte per cycle while in_tready is high; the output register and
// skid entry hold two results, so in_tready drops only once a stall fills the skid.
// Reset (rst_n low, synchronous) returns the parser to idle and empties the output.
module midi_meta_event_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] value
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // text_end
);

  mmep_pkg::res_t res;
  logic           byte_accept;
  logic           space_ok;

  assign in_tready   = space_ok;
  assign byte_accept = in_tvalid && space_ok;

  mmep_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .data_byte   (in_tdata),
    .last_byte   (in_tlast),
    .res         (res)
  );

  mmep_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .space_ok   (space_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .kind       (out_tuser),
    .value      (out_tdata),
    .text_end   (out_tlast)
  );

endmodule
